>>> sv/kiss_deframer_command_responder_defines.svh
// ---------------------------------------------------------------------------
// KISS deframer assertion macros
// Clocked, reset-qualified concurrent assertion helpers for the deframer.
// ---------------------------------------------------------------------------
`ifndef KISS_DEFRAMER_COMMAND_RESPONDER_DEFINES_SVH
`define KISS_DEFRAMER_COMMAND_RESPONDER_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define KDCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define KDCR_NEVER(lbl, cond, msg) \
  `KDCR_ASSERT(lbl, !(cond), msg)

`endif

>>> sv/kdcr_pkg.sv
// ---------------------------------------------------------------------------
// KISS deframer package
// Framing bytes, command codes, sequencer states and control structs.
// ---------------------------------------------------------------------------
package kdcr_pkg;

  // KISS framing bytes
  localparam logic [7:0] FEND_B  = 8'hC0;
  localparam logic [7:0] FESC_B  = 8'hDB;
  localparam logic [7:0] TFEND_B = 8'hDC;
  localparam logic [7:0] TFESC_B = 8'hDD;

  // Command codes
  localparam logic [7:0] CMD_PAYLOAD   = 8'h00;
  localparam logic [7:0] CMD_RADIO_LO  = 8'h01;
  localparam logic [7:0] CMD_RADIO_HI  = 8'h05;
  localparam logic [7:0] CMD_RSTATE    = 8'h06;
  localparam logic [7:0] CMD_PROBE     = 8'h08;
  localparam logic [7:0] CMD_SNIFF     = 8'h0E;
  localparam logic [7:0] CMD_RDY       = 8'h0F;
  localparam logic [7:0] CMD_STATS_A   = 8'h21;
  localparam logic [7:0] CMD_STATS_B   = 8'h22;
  localparam logic [7:0] CMD_BRD_MODEL = 8'h47;
  localparam logic [7:0] CMD_PLAT      = 8'h48;
  localparam logic [7:0] CMD_MCU       = 8'h49;
  localparam logic [7:0] CMD_FW        = 8'h50;

  // Special payload values
  localparam logic [7:0] PROBE_REQ = 8'h73;
  localparam logic [7:0] PROBE_ANS = 8'h46;
  localparam logic [7:0] VAL_ON    = 8'h01;

  // Configuration register indexes
  localparam logic [2:0] REG_BOARD    = 3'd0;
  localparam logic [2:0] REG_PLATFORM = 3'd1;
  localparam logic [2:0] REG_MCU      = 3'd2;
  localparam logic [2:0] REG_FW_HI    = 3'd3;
  localparam logic [2:0] REG_FW_LO    = 3'd4;

  // Reset values of the configuration registers
  localparam logic [7:0] RST_BOARD    = 8'd66;
  localparam logic [7:0] RST_PLATFORM = 8'd128;
  localparam logic [7:0] RST_MCU      = 8'd135;
  localparam logic [7:0] RST_FW_HI    = 8'd1;
  localparam logic [7:0] RST_FW_LO    = 8'd89;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPEN,
    ST_CMD,
    ST_BODY,
    ST_ESC2,
    ST_CLOSE,
    ST_DATA
  } state_e;

  typedef enum logic [2:0] {
    SEL_FEND,
    SEL_FESC,
    SEL_TFEND,
    SEL_TFESC,
    SEL_CMD,
    SEL_BODY,
    SEL_STORE
  } sel_e;

  // Controller to datapath
  typedef struct packed {
    logic take;
    logic load;
    sel_e sel;
    logic chan;
    logic last;
    logic idx_inc;
    logic second_set;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_act;
    logic start_data;
    logic out_free;
    logic body_special;
    logic body_is_fend;
    logic body_empty;
    logic body_last;
    logic data_last;
    logic need_second;
  } dp_stat_t;

endpackage

>>> sv/kiss_deframer_command_responder.sv
// Input bytes are taken while no response is being sent.
// A frame end that triggers a response stalls the input until the last of its
// results, up to 33, is loaded into the output register, one result per cycle
// while the output is not stalled; the first result is loaded once the state
// register has left idle after the frame end transfer.
// Asynchronous active-low reset clears control state and loads register defaults.
// ---------------------------------------------------------------------------
// KISS deframer and command responder
// Unescapes host frames and answers commands on host and data channels.
// ---------------------------------------------------------------------------
`include "kiss_deframer_command_responder_defines.svh"

module kiss_deframer_command_responder import kdcr_pkg::*; #(
  parameter int FRAME_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        channel_o,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic [15:0] dropped_frames_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Handshake views used by the checks
  logic byte_xfer, mid_xfer, last_xfer, last_held, idle_stall;

  // Controller
  kdcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // Datapath
  kdcr_dp #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .byte_in_i        (byte_in_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .channel_o        (channel_o),
    .out_byte_o       (out_byte_o),
    .last_o           (last_o),
    .dropped_frames_o (dropped_frames_o),
    .cmd_i            (dp_cmd),
    .stat_o           (dp_stat)
  );

  assign byte_xfer  = in_valid_i && !in_stall_o && (byte_in_i != FEND_B);
  assign mid_xfer   = out_valid_o && !out_stall_i && !last_o;
  assign last_xfer  = out_valid_o && !out_stall_i && last_o;
  assign last_held  = out_valid_o && last_o;
  assign idle_stall = in_stall_o && !out_valid_o;

  // Only a frame end can start a response
  `KDCR_ASSERT(a_no_resp_without_fend, byte_xfer |=> !in_stall_o, "response without frame end")

  // After a non-final transfer the response is still running or its final result waits
  `KDCR_ASSERT(a_busy_until_last, mid_xfer |=> (in_stall_o || last_held), "no final result")

  // Never stall the input with an empty output right after a final result
  `KDCR_NEVER(a_stall_has_work, idle_stall && $past(in_stall_o && last_xfer), "stall after last")

endmodule

>>> sv/kdcr_ctrl.sv
// ---------------------------------------------------------------------------
// KISS deframer controller
// Sequences input transfers and the result bytes of each response frame.
// ---------------------------------------------------------------------------
module kdcr_ctrl import kdcr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d           = state_q;
    in_stall_o        = (state_q != ST_IDLE);
    cmd_o.take        = 1'b0;
    cmd_o.load        = 1'b0;
    cmd_o.sel         = SEL_FEND;
    cmd_o.chan        = 1'b0;
    cmd_o.last        = 1'b0;
    cmd_o.idx_inc     = 1'b0;
    cmd_o.second_set  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        cmd_o.take = in_valid_i;
        if (in_valid_i && stat_i.start_act) begin
          state_d = stat_i.start_data ? ST_DATA : ST_OPEN;
        end
      end
      ST_OPEN: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.sel  = SEL_FEND;
          state_d    = ST_CMD;
        end
      end
      ST_CMD: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.sel  = SEL_CMD;
          state_d    = stat_i.body_empty ? ST_CLOSE : ST_BODY;
        end
      end
      ST_BODY: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          if (stat_i.body_special) begin
            // escape marker first, substitute next
            cmd_o.sel = SEL_FESC;
            state_d   = ST_ESC2;
          end else begin
            cmd_o.sel     = SEL_BODY;
            cmd_o.idx_inc = 1'b1;
            state_d       = stat_i.body_last ? ST_CLOSE : ST_BODY;
          end
        end
      end
      ST_ESC2: begin
        if (stat_i.out_free) begin
          cmd_o.load    = 1'b1;
          cmd_o.sel     = stat_i.body_is_fend ? SEL_TFEND : SEL_TFESC;
          cmd_o.idx_inc = 1'b1;
          state_d       = stat_i.body_last ? ST_CLOSE : ST_BODY;
        end
      end
      ST_CLOSE: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.sel  = SEL_FEND;
          cmd_o.last = !stat_i.need_second;
          if (stat_i.need_second) begin
            cmd_o.second_set = 1'b1;
            state_d          = ST_OPEN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_DATA: begin
        if (stat_i.out_free) begin
          cmd_o.load    = 1'b1;
          cmd_o.sel     = SEL_STORE;
          cmd_o.chan    = 1'b1;
          cmd_o.last    = stat_i.data_last;
          cmd_o.idx_inc = 1'b1;
          if (stat_i.data_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/kdcr_dp.sv
// ---------------------------------------------------------------------------
// KISS deframer datapath
// Unescapes and stores frames, holds registers, builds answer bytes and
// drives the output register.
// ---------------------------------------------------------------------------
module kdcr_dp import kdcr_pkg::*; #(
  parameter int FRAME_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  byte_in_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic        channel_o,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic [15:0] dropped_frames_o,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o
);

  localparam int LEN_W = $clog2(FRAME_BYTES + 1);
  localparam int CNT_W = (LEN_W > 3) ? LEN_W : 3;
  localparam int IDX_W = $clog2(FRAME_BYTES);

  // Configuration registers
  logic [7:0] board_q, platform_q, mcu_q, fw_hi_q, fw_lo_q;

  // Deframer state
  logic             inside_q, esc_q, ovf_q;
  logic [LEN_W-1:0] len_q;
  logic [15:0]      drop_q;
  logic [7:0]       store_q [FRAME_BYTES];
  logic [7:0]       cmd_q, val_q;

  // Response state
  logic [LEN_W-1:0] alen_q;
  logic [7:0]       aval_q;
  logic             second_q;
  logic [CNT_W-1:0] idx_q, idx_d;

  // Output register
  logic             out_valid_q, chan_q, last_q;
  logic [7:0]       obyte_q;
  logic [15:0]      odrop_q;

  logic [7:0]       unesc_byte;
  logic [7:0]       cur_val;
  logic             act_ok;
  logic [7:0]       frame_cmd;
  logic [CNT_W-1:0] body_len;
  logic [7:0]       body_byte;
  logic [CNT_W-1:0] ptr_full;
  logic [CNT_W-1:0] rd_full;
  logic [IDX_W-1:0] rd_ptr;
  logic [7:0]       store_rd_q;
  logic [7:0]       sel_byte;
  logic             is_fend;

  assign is_fend = (byte_in_i == FEND_B);

  // Map escaped substitutes back to framing bytes
  always_comb begin
    unesc_byte = byte_in_i;
    if (esc_q) begin
      if (byte_in_i == TFEND_B) begin
        unesc_byte = FEND_B;
      end else if (byte_in_i == TFESC_B) begin
        unesc_byte = FESC_B;
      end
    end
  end

  // First payload byte, zero when missing
  assign cur_val = (len_q >= LEN_W'(2)) ? val_q : 8'h00;

  // Decide whether the closing frame end produces results
  always_comb begin
    unique case (cmd_q) inside
      CMD_PAYLOAD:                act_ok = (len_q >= LEN_W'(2));
      [CMD_RADIO_LO:CMD_RADIO_HI]: act_ok = 1'b1;
      CMD_PROBE:                  act_ok = (cur_val == PROBE_REQ);
      CMD_BRD_MODEL, CMD_PLAT, CMD_MCU, CMD_FW,
      CMD_RSTATE, CMD_RDY, CMD_SNIFF,
      CMD_STATS_A, CMD_STATS_B:   act_ok = 1'b1;
      default:                    act_ok = 1'b0;
    endcase
  end

  assign stat_o.start_act  = is_fend && inside_q && !ovf_q && (len_q != '0) && act_ok;
  assign stat_o.start_data = (cmd_q == CMD_PAYLOAD);

  // Next body index
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.take || cmd_i.second_set) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + CNT_W'(1);
    end
  end

  // Store read port, one past the body index
  assign ptr_full = idx_q + CNT_W'(1);
  assign rd_full  = idx_d + CNT_W'(1);
  assign rd_ptr   = rd_full[IDX_W-1:0];

  // Read ahead so the data is ready when the index settles
  always_ff @(posedge clk_i) begin
    store_rd_q <= store_q[rd_ptr];
  end

  // Answer body length and bytes per command
  assign frame_cmd = second_q ? CMD_RDY : cmd_q;

  always_comb begin
    unique case (frame_cmd) inside
      [CMD_RADIO_LO:CMD_RADIO_HI]: begin
        body_len  = CNT_W'(alen_q) - CNT_W'(1);
        body_byte = store_rd_q;
      end
      CMD_PROBE: begin
        body_len  = CNT_W'(1);
        body_byte = PROBE_ANS;
      end
      CMD_BRD_MODEL: begin
        body_len  = CNT_W'(1);
        body_byte = board_q;
      end
      CMD_PLAT: begin
        body_len  = CNT_W'(1);
        body_byte = platform_q;
      end
      CMD_MCU: begin
        body_len  = CNT_W'(1);
        body_byte = mcu_q;
      end
      CMD_FW: begin
        body_len  = CNT_W'(2);
        body_byte = (idx_q == '0) ? fw_hi_q : fw_lo_q;
      end
      CMD_RSTATE: begin
        body_len  = CNT_W'(1);
        body_byte = {7'd0, (aval_q == VAL_ON)};
      end
      CMD_RDY: begin
        body_len  = CNT_W'(1);
        body_byte = VAL_ON;
      end
      CMD_SNIFF: begin
        body_len  = CNT_W'(1);
        body_byte = aval_q;
      end
      CMD_STATS_A, CMD_STATS_B: begin
        body_len  = CNT_W'(4);
        body_byte = 8'h00;
      end
      default: begin
        body_len  = '0;
        body_byte = 8'h00;
      end
    endcase
  end

  assign stat_o.body_is_fend = (body_byte == FEND_B);
  assign stat_o.body_special = (body_byte == FEND_B) || (body_byte == FESC_B);
  assign stat_o.body_empty   = (body_len == '0);
  assign stat_o.body_last    = (ptr_full == body_len);
  assign stat_o.data_last    = ((CNT_W+1)'(idx_q) + (CNT_W+1)'(2)) == (CNT_W+1)'(alen_q);
  assign stat_o.need_second  = !second_q && (cmd_q == CMD_RSTATE) && (aval_q == VAL_ON);
  assign stat_o.out_free     = !out_valid_q || !out_stall_i;

  // Configuration writes; indexes past the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_q    <= RST_BOARD;
      platform_q <= RST_PLATFORM;
      mcu_q      <= RST_MCU;
      fw_hi_q    <= RST_FW_HI;
      fw_lo_q    <= RST_FW_LO;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BOARD:    board_q    <= cfg_data_i;
        REG_PLATFORM: platform_q <= cfg_data_i;
        REG_MCU:      mcu_q      <= cfg_data_i;
        REG_FW_HI:    fw_hi_q    <= cfg_data_i;
        REG_FW_LO:    fw_lo_q    <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // Deframe one input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      esc_q    <= 1'b0;
      ovf_q    <= 1'b0;
      len_q    <= '0;
      drop_q   <= '0;
    end else if (cmd_i.take) begin
      if (is_fend) begin
        inside_q <= 1'b1;
        esc_q    <= 1'b0;
        ovf_q    <= 1'b0;
        len_q    <= '0;
      end else if (inside_q && !ovf_q) begin
        if (byte_in_i == FESC_B) begin
          esc_q <= 1'b1;
        end else begin
          esc_q <= 1'b0;
          if (len_q < LEN_W'(FRAME_BYTES)) begin
            len_q <= len_q + LEN_W'(1);
          end else begin
            // frame too long: drop up to the next frame end
            ovf_q  <= 1'b1;
            drop_q <= drop_q + 16'd1;
          end
        end
      end
    end
  end

  // Frame store and captured command and first payload byte
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && !is_fend && inside_q && !ovf_q && (byte_in_i != FESC_B) &&
        (len_q < LEN_W'(FRAME_BYTES))) begin
      store_q[len_q[IDX_W-1:0]] <= unesc_byte;
      if (len_q == '0) begin
        cmd_q <= unesc_byte;
      end
      if (len_q == LEN_W'(1)) begin
        val_q <= unesc_byte;
      end
    end
  end

  // Latch the frame being answered at its frame end
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && is_fend) begin
      alen_q <= len_q;
      aval_q <= cur_val;
    end
  end

  // Response index and second-frame flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      second_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (cmd_i.take) begin
        second_q <= 1'b0;
      end else if (cmd_i.second_set) begin
        second_q <= 1'b1;
      end
    end
  end

  // Pick the result byte
  always_comb begin
    case (cmd_i.sel)
      SEL_FEND:  sel_byte = FEND_B;
      SEL_FESC:  sel_byte = FESC_B;
      SEL_TFEND: sel_byte = TFEND_B;
      SEL_TFESC: sel_byte = TFESC_B;
      SEL_CMD:   sel_byte = frame_cmd;
      SEL_BODY:  sel_byte = body_byte;
      SEL_STORE: sel_byte = store_rd_q;
      default:   sel_byte = FEND_B;
    endcase
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      chan_q  <= cmd_i.chan;
      obyte_q <= sel_byte;
      last_q  <= cmd_i.last;
      odrop_q <= drop_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign channel_o        = chan_q;
  assign out_byte_o       = obyte_q;
  assign last_o           = last_q;
  assign dropped_frames_o = odrop_q;

endmodule
